>>> rtl/lpbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbs_pkg
// shared types and constants of the length-prefixed byte stuffing framer
// ----------------------------------------------------------------------------
package lpbs_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_DATA  = 1'b1;

   // longest run of line bytes caused by one item
   localparam int MAX_RUN   = 5;
   localparam int RUN_IDX_W = $clog2(MAX_RUN);

   typedef struct packed {
      logic        action;
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_end;
   } rsp_type;

   function automatic logic needs_escape(input logic [7:0] b);
      needs_escape = (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

>>> rtl/length_prefixed_byte_stuffing_framer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_byte_stuffing_framer_top
// turns frame-start and payload items into a stuffed byte stream
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid / req_stall / req_data) takes one item per
//   handshake: a frame start carrying the 16-bit length, or a payload byte.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) gives one line byte per
//   handshake with last_of_run on the final byte of an item and frame_end
//   on the byte completing the announced payload or an empty frame's length.
// order: an accepted item is first held in the run register; its bytes
//   then move to the rsp register, one byte per cycle while not stalled.
// pacing: an item causes 1 or 2 line bytes for a payload byte and 3 to 5
//   for a frame start; the single byte-wide rsp register passes them on
//   one at a time. the next item is taken in the cycle its predecessor's
//   last byte moves into the rsp register.
// reset: synchronous; empties the run register and the rsp register and
//   clears the count of payload bytes still owed.
// stall: a stalled rsp byte holds; the run register then holds too and
//   req_stall stays high until the run drains.
// ----------------------------------------------------------------------------
module length_prefixed_byte_stuffing_framer_top
   import lpbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // run register: the expanded line bytes of the item in flight
   logic [7:0]           run_ff [MAX_RUN];
   logic [7:0]           run_in [MAX_RUN];
   logic [RUN_IDX_W-1:0] last_ff, last_in;   // index of the run's final byte
   logic [RUN_IDX_W-1:0] idx_ff;             // next byte to send
   logic                 end_ff, end_in;     // final byte closes the frame
   logic                 run_valid_ff;

   // payload bytes still owed in the current frame
   logic [15:0] remaining_ff, remaining_in;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic accept;
   logic move;       // a byte of the run goes to the rsp register
   logic run_last;   // the byte at idx is the run's final one

   logic [7:0] hi_byte, lo_byte;
   logic       hi_esc, lo_esc;

   assign run_last  = (idx_ff == last_ff);
   assign move      = run_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = run_valid_ff && !(move && run_last);
   assign accept    = req_valid && !req_stall;

   assign hi_byte = req_data.frame_length[15:8];
   assign lo_byte = req_data.frame_length[7:0];
   assign hi_esc  = needs_escape(hi_byte);
   assign lo_esc  = needs_escape(lo_byte);

   // expand the incoming item into its line bytes
   always_comb begin
      for (int i = 0; i < MAX_RUN; i++) begin
         run_in[i] = FLAG_BYTE;
      end
      last_in      = '0;
      end_in       = 1'b0;
      remaining_in = remaining_ff;
      if (req_data.action == ACTION_START) begin
         run_in[0] = FLAG_BYTE;
         case ({hi_esc, lo_esc})
            2'b00: begin
               run_in[1] = hi_byte;
               run_in[2] = lo_byte;
               last_in   = RUN_IDX_W'(2);
            end
            2'b01: begin
               run_in[1] = hi_byte;
               run_in[2] = ESC_BYTE;
               run_in[3] = lo_byte ^ ESC_XOR;
               last_in   = RUN_IDX_W'(3);
            end
            2'b10: begin
               run_in[1] = ESC_BYTE;
               run_in[2] = hi_byte ^ ESC_XOR;
               run_in[3] = lo_byte;
               last_in   = RUN_IDX_W'(3);
            end
            default: begin
               run_in[1] = ESC_BYTE;
               run_in[2] = hi_byte ^ ESC_XOR;
               run_in[3] = ESC_BYTE;
               run_in[4] = lo_byte ^ ESC_XOR;
               last_in   = RUN_IDX_W'(4);
            end
         endcase
         // empty frame ends on the length itself
         end_in       = (req_data.frame_length == 16'd0);
         remaining_in = req_data.frame_length;
      end else begin
         if (needs_escape(req_data.data_byte)) begin
            run_in[0] = ESC_BYTE;
            run_in[1] = req_data.data_byte ^ ESC_XOR;
            last_in   = RUN_IDX_W'(1);
         end else begin
            run_in[0] = req_data.data_byte;
         end
         // excess payload keeps the count at zero and never ends a frame
         if (remaining_ff != 16'd0) begin
            remaining_in = remaining_ff - 16'd1;
            end_in       = (remaining_ff == 16'd1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remaining_ff <= '0;
         idx_ff       <= '0;
      end else begin
         if (accept) begin
            run_valid_ff <= 1'b1;
            idx_ff       <= '0;
            remaining_ff <= remaining_in;
         end else if (move) begin
            if (run_last) begin
               run_valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + RUN_IDX_W'(1);
            end
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         run_ff  <= run_in;
         last_ff <= last_in;
         end_ff  <= end_in;
      end
      if (move) begin
         rsp_data_ff.out_byte    <= run_ff[idx_ff];
         rsp_data_ff.last_of_run <= run_last;
         rsp_data_ff.frame_end   <= run_last && end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/lpbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbs_checker
// port-level checks of the framer, bound to the top level
// ----------------------------------------------------------------------------
module lpbs_checker
   import lpbs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp byte changed while stalled");

   // frame end only on an item's final byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.last_of_run)
      else $error("frame_end without last_of_run");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a frame start causes at least three bytes, so the next item must wait
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.action == ACTION_START) |=> req_stall)
      else $error("item taken right after a frame start");

endmodule

bind length_prefixed_byte_stuffing_framer_top lpbs_checker u_lpbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
